FILE: hw/rtl/ptt_pkg.sv
// Shared types and constants for the periodic timer table.
package ptt_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int MAX_RESULTS    = 16;
  localparam logic [15:0] STEP_RESET = 16'd10;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_FIRE   = 2'd2
  } kind_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] period;
    logic [15:0] tag;
    logic [3:0]  slot;
  } req_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  slot_out;
    logic [15:0] tag_out;
    logic        status;
    logic        last;
  } rsp_t;

endpackage

FILE: hw/rtl/ptt_slot_mem.sv
// Slot memory: one write port, one read port, registered read data.
module ptt_slot_mem #(
  parameter int DEPTH = ptt_pkg::SLOTS_DEF,
  parameter int WIDTH = 48
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/periodic_timer_table_core.sv
// Periodic timer table: tick counter, slot scan and add/remove handling.
// Tick: one slot read per cycle from the slot memory unless a fire beat waits on
//   a stalled output; each fire beat is held until the next due slot or scan end.
// Add: free-slot search one slot per cycle, then the answer. Remove: one slot check.
// Unknown op: dropped without an answer. Output stalls delay answers and fire beats.
// Reset clears the counter, the active bits and the output; step returns to 10.
module periodic_timer_table_core #(
  parameter int SLOTS      = ptt_pkg::SLOTS_DEF,
  parameter int COUNT_BITS = ptt_pkg::COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  ptt_pkg::req_t    req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output ptt_pkg::rsp_t    rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_data
);

  localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FIRE_BITS = $clog2(ptt_pkg::MAX_RESULTS + 1);

  typedef struct packed {
    logic [COUNT_BITS-1:0] deadline;
    logic [15:0]           period;
    logic [15:0]           tag;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_ADD,
    ST_REMOVE,
    ST_RESP
  } state_t;

  state_t                state;
  logic [15:0]           step;
  logic [COUNT_BITS-1:0] count;
  logic [SLOTS-1:0]      active;
  ptt_pkg::req_t         cur;
  logic [SLOT_BITS-1:0]  idx;
  logic                  held_vld;
  logic [3:0]            held_slot;
  logic [15:0]           held_tag;
  logic [FIRE_BITS-1:0]  fire_cnt;
  ptt_pkg::rsp_t         res;

  entry_t                rd_entry;
  entry_t                wr_entry;
  logic                  wr_en;
  logic [SLOT_BITS-1:0]  rd_addr;
  logic [SLOT_BITS-1:0]  rm_idx;
  logic                  rm_ok;
  logic                  last_idx;
  logic                  can_load;
  logic                  due;
  logic                  keep;
  logic                  scan_go;
  logic                  rsp_load;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);

  assign last_idx = (idx == SLOT_BITS'(SLOTS - 1));
  assign can_load = !rsp_valid || !rsp_stall;
  assign due      = active[idx] && (rd_entry.deadline == count);
  assign keep     = due && (fire_cnt < FIRE_BITS'(ptt_pkg::MAX_RESULTS));
  assign scan_go  = (state == ST_SCAN) && !(keep && held_vld && !can_load);
  assign rm_idx   = SLOT_BITS'(cur.slot);
  assign rm_ok    = (int'(cur.slot) < SLOTS) && active[rm_idx];
  assign rsp_load = (scan_go && keep && held_vld) ||
                    ((state == ST_FLUSH) && held_vld && can_load) ||
                    ((state == ST_RESP) && can_load);

  always_comb begin
    if (state == ST_SCAN) begin
      rd_addr = scan_go ? SLOT_BITS'(idx + 1'b1) : idx;
    end else begin
      rd_addr = '0;
    end
  end

  always_comb begin
    if (state == ST_SCAN) begin
      wr_en             = scan_go && due;
      wr_entry.deadline = count + COUNT_BITS'(rd_entry.period);
      wr_entry.period   = rd_entry.period;
      wr_entry.tag      = rd_entry.tag;
    end else begin
      wr_en             = (state == ST_ADD) && !active[idx];
      wr_entry.deadline = count + COUNT_BITS'(cur.period);
      wr_entry.period   = cur.period;
      wr_entry.tag      = cur.tag;
    end
  end

  ptt_slot_mem #(
    .DEPTH (SLOTS),
    .WIDTH ($bits(entry_t))
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= ptt_pkg::STEP_RESET;
      count     <= '0;
      active    <= '0;
      idx       <= '0;
      held_vld  <= 1'b0;
      fire_cnt  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        step <= cfg_data;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            cur      <= req;
            idx      <= '0;
            fire_cnt <= '0;
            held_vld <= 1'b0;
            case (req.op)
              ptt_pkg::OP_TICK: begin
                count <= count + COUNT_BITS'(step);
                state <= ST_SCAN;
              end
              ptt_pkg::OP_ADD:    state <= ST_ADD;
              ptt_pkg::OP_REMOVE: state <= ST_REMOVE;
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_go) begin
            if (keep) begin
              if (held_vld) begin
                rsp       <= '{kind: ptt_pkg::KIND_FIRE, slot_out: held_slot,
                               tag_out: held_tag, status: 1'b0, last: 1'b0};
              end
              held_vld  <= 1'b1;
              held_slot <= 4'(idx);
              held_tag  <= rd_entry.tag;
              fire_cnt  <= fire_cnt + 1'b1;
            end
            if (last_idx) begin
              state <= ST_FLUSH;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (!held_vld) begin
            state <= ST_IDLE;
          end else if (can_load) begin
            rsp       <= '{kind: ptt_pkg::KIND_FIRE, slot_out: held_slot,
                           tag_out: held_tag, status: 1'b0, last: 1'b1};
            held_vld  <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        ST_ADD: begin
          if (!active[idx]) begin
            active[idx] <= 1'b1;
            res   <= '{kind: ptt_pkg::KIND_ADD, slot_out: 4'(idx),
                       tag_out: 16'd0, status: 1'b0, last: 1'b1};
            state <= ST_RESP;
          end else if (last_idx) begin
            res   <= '{kind: ptt_pkg::KIND_ADD, slot_out: 4'd0,
                       tag_out: 16'd0, status: 1'b1, last: 1'b1};
            state <= ST_RESP;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_REMOVE: begin
          if (rm_ok) begin
            active[rm_idx] <= 1'b0;
          end
          res   <= '{kind: ptt_pkg::KIND_REMOVE, slot_out: cur.slot,
                     tag_out: 16'd0, status: !rm_ok, last: 1'b1};
          state <= ST_RESP;
        end
        ST_RESP: begin
          if (can_load) begin
            rsp       <= res;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/ptt_core_check.sv
// Port-level checks for the periodic timer table, bound to the top level.
module ptt_core_check (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input ptt_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result beat changed");

  a_answer_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.kind == ptt_pkg::KIND_ADD || rsp.kind == ptt_pkg::KIND_REMOVE)
      |-> rsp.last)
    else $error("add or remove answer not marked last");

  a_answer_tag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind != ptt_pkg::KIND_FIRE |-> rsp.tag_out == 16'd0)
    else $error("answer beat carries a tag");

  a_fire_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind == ptt_pkg::KIND_FIRE |-> !rsp.status)
    else $error("fire beat with error status");

  a_full_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind == ptt_pkg::KIND_ADD && rsp.status |-> rsp.slot_out == 4'd0)
    else $error("full answer names a slot");

endmodule

bind periodic_timer_table_core ptt_core_check u_check (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
